>>> hw/rtl/swcc_pkg.sv
// ----------------------------------------------------------------------------
// swcc_pkg
// Shared types, constants and the CRC-8 byte update for the sensor word
// CRC checker.
// ----------------------------------------------------------------------------
package swcc_pkg;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_TOP  = 8'h80;

  // Byte position inside a three-byte group
  localparam logic [1:0] GRP_DATA_HI = 2'd0;
  localparam logic [1:0] GRP_DATA_LO = 2'd1;
  localparam logic [1:0] GRP_CHECK   = 2'd2;

  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 24;

  typedef struct packed {
    logic [15:0] word;
    logic        crc_ok;
    logic        error_seen;
    logic        short_group;
    logic        last;
  } swcc_result_t;

  typedef struct packed {
    logic [1:0] group_pos;
    logic       sticky_error;
  } swcc_status_t;

  // MSB-first CRC-8 update over one byte
  function automatic logic [7:0] crc8_absorb(logic [7:0] acc, logic [7:0] b);
    logic [7:0] v;
    v = acc ^ b;
    for (int i = 0; i < 8; i++) begin
      if ((v & CRC_TOP) != 8'h00) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

>>> hw/rtl/swcc_in_stage.sv
// ----------------------------------------------------------------------------
// swcc_in_stage
// Input register: captures one received byte and its end-of-transfer mark.
// ----------------------------------------------------------------------------
module swcc_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  output logic       s_ready_o,
  input  logic [7:0] s_byte_i,
  input  logic       s_eot_i,
  input  logic       consume_i,
  output logic       valid_o,
  output logic [7:0] byte_o,
  output logic       eot_o
);
  import swcc_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       eot_q;
  logic       load;

  assign s_ready_o = !valid_q || consume_i;
  assign load      = s_valid_i && s_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (consume_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= s_byte_i;
      eot_q  <= s_eot_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;
  assign eot_o   = eot_q;

endmodule

>>> hw/rtl/swcc_group_core.sv
// ----------------------------------------------------------------------------
// swcc_group_core
// Group state (running CRC, position, data bytes, sticky error) and the
// result logic for one byte.
// ----------------------------------------------------------------------------
module swcc_group_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [7:0]             byte_i,
  input  logic                   eot_i,
  input  logic                   consume_i,
  output logic                   emit_o,
  output swcc_pkg::swcc_result_t result_o,
  output swcc_pkg::swcc_status_t status_o
);
  import swcc_pkg::*;

  logic [7:0] crc_q, crc_d;
  logic [1:0] pos_q, pos_d;
  logic [7:0] high_q, high_d;
  logic [7:0] low_q, low_d;
  logic       sticky_q, sticky_d;
  logic       ok;
  logic       sticky_upd;

  always_comb begin
    crc_d      = crc_q;
    pos_d      = pos_q;
    high_d     = high_q;
    low_d      = low_q;
    sticky_d   = sticky_q;
    emit_o     = 1'b0;
    result_o   = '0;
    ok         = (crc_q == byte_i);
    sticky_upd = sticky_q || !ok;

    unique case (pos_q)
      GRP_CHECK: begin
        emit_o               = 1'b1;
        result_o.word        = {high_q, low_q};
        result_o.crc_ok      = ok;
        result_o.error_seen  = sticky_upd;
        result_o.short_group = 1'b0;
        result_o.last        = eot_i;
        crc_d                = CRC_INIT;
        pos_d                = GRP_DATA_HI;
        high_d               = 8'h00;
        low_d                = 8'h00;
        sticky_d             = sticky_upd;
      end
      GRP_DATA_LO: begin
        emit_o               = eot_i;
        result_o.word        = {high_q, byte_i};
        result_o.error_seen  = 1'b1;
        result_o.short_group = 1'b1;
        result_o.last        = 1'b1;
        crc_d                = crc8_absorb(crc_q, byte_i);
        low_d                = byte_i;
        pos_d                = GRP_CHECK;
      end
      default: begin
        // position 0, and the unreachable code 3 acts the same
        emit_o               = eot_i;
        result_o.word        = {byte_i, low_q};
        result_o.error_seen  = 1'b1;
        result_o.short_group = 1'b1;
        result_o.last        = 1'b1;
        crc_d                = crc8_absorb(crc_q, byte_i);
        high_d               = byte_i;
        pos_d                = GRP_DATA_LO;
      end
    endcase

    // end of transfer: drop everything back to reset values
    if (eot_i) begin
      crc_d    = CRC_INIT;
      pos_d    = GRP_DATA_HI;
      high_d   = 8'h00;
      low_d    = 8'h00;
      sticky_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q    <= CRC_INIT;
      pos_q    <= GRP_DATA_HI;
      high_q   <= 8'h00;
      low_q    <= 8'h00;
      sticky_q <= 1'b0;
    end else if (consume_i) begin
      crc_q    <= crc_d;
      pos_q    <= pos_d;
      high_q   <= high_d;
      low_q    <= low_d;
      sticky_q <= sticky_d;
    end
  end

  assign status_o.group_pos    = pos_q;
  assign status_o.sticky_error = sticky_q;

endmodule

>>> hw/rtl/swcc_out_stage.sv
// ----------------------------------------------------------------------------
// swcc_out_stage
// Result register on the master side of the stream.
// ----------------------------------------------------------------------------
module swcc_out_stage (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                load_i,
  input  swcc_pkg::swcc_result_t              result_i,
  output logic                                free_o,
  output logic                                m_valid_o,
  input  logic                                m_ready_i,
  output logic [swcc_pkg::OUT_DATA_W-1:0]     m_data_o,
  output logic                                m_user_o,
  output logic                                m_last_o
);
  import swcc_pkg::*;

  logic         valid_q, valid_d;
  swcc_result_t res_q;

  assign free_o = !valid_q || m_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign m_valid_o = valid_q;
  assign m_data_o  = {6'b0, res_q.error_seen, res_q.crc_ok, res_q.word};
  assign m_user_o  = res_q.short_group;
  assign m_last_o  = res_q.last;

endmodule

>>> hw/rtl/sensor_word_crc_checker_unit.sv
// ----------------------------------------------------------------------------
// sensor_word_crc_checker_unit
// Checks CRC-8 (poly 0x31, init 0xFF) on groups of two data bytes plus a
// check byte and reports each word with its check status.
//
//   channel  dir  tdata                               tuser        tlast
//   s_axis   in   [7:0] rx_byte                       -            end_of_transfer
//   m_axis   out  [15:0] word, [16] crc_ok,           short_group  last
//                 [17] error_seen, [23:18] zero
//
// One byte per cycle unless a result is held up by a full m_axis; between its
// byte's acceptance on s_axis and m_axis a result passes the input register,
// then the result register.
// The CRC update is byte-wide combinational XOR logic between the input register and the group state.
// Reset puts the group state at position zero with the CRC at 0xFF.
// A stalled m_axis holds one result; bytes that make no result keep flowing.
// ----------------------------------------------------------------------------
module sensor_word_crc_checker_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [swcc_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  logic                            s_axis_tlast_i,   // end_of_transfer
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [swcc_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,   // word, crc_ok, error_seen
  output logic                            m_axis_tuser_o,   // short_group
  output logic                            m_axis_tlast_o    // last
);
  import swcc_pkg::*;

  logic         item_valid;
  logic [7:0]   item_byte;
  logic         item_eot;
  logic         consume;
  logic         emit;
  logic         out_free;
  swcc_result_t result;
  swcc_status_t status;

  // advance a byte unless it makes a result and the output is still full
  assign consume = item_valid && (!emit || out_free);

  swcc_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .s_byte_i  (s_axis_tdata_i),
    .s_eot_i   (s_axis_tlast_i),
    .consume_i (consume),
    .valid_o   (item_valid),
    .byte_o    (item_byte),
    .eot_o     (item_eot)
  );

  swcc_group_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_i    (item_byte),
    .eot_i     (item_eot),
    .consume_i (consume),
    .emit_o    (emit),
    .result_o  (result),
    .status_o  (status)
  );

  swcc_out_stage u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (consume && emit),
    .result_i  (result),
    .free_o    (out_free),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_data_o  (m_axis_tdata_o),
    .m_user_o  (m_axis_tuser_o),
    .m_last_o  (m_axis_tlast_o)
  );

  a_short_is_final_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |->
      m_axis_tlast_o && m_axis_tdata_o[17] && !m_axis_tdata_o[16])
    else $error("short group result without last/error or with crc_ok");

  a_fail_sets_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[16] |-> m_axis_tdata_o[17])
    else $error("failed check not reflected in error_seen");

  a_group_pos_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.group_pos != 2'd3)
    else $error("group position reached unused code");

  a_eot_clears_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume && item_eot |=> !status.sticky_error && status.group_pos == GRP_DATA_HI)
    else $error("state not cleared after end of transfer");

endmodule

>>> verif/tb_sensor_word_crc_checker_unit.sv
// ----------------------------------------------------------------------------
// tb_sensor_word_crc_checker_unit
// Self-checking bench for the sensor word CRC checker. A short table of
// directed bytes covers good and bad check bytes, short groups at both data
// positions and the sticky transfer error. Random transfers follow, mostly
// well formed with a correct CRC, some corrupted, cut short or pure noise.
// Every result word is compared field by field with the in-bench model or a typed table row.
// ----------------------------------------------------------------------------
module tb_sensor_word_crc_checker_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import swcc_pkg::*;

  localparam int unsigned RANDOM_BYTES   = 500;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 8;

  localparam int KIND_FULL  = 0;
  localparam int KIND_SHORT = 1;
  localparam int KIND_NOISE = 2;

  typedef struct packed {
    logic [7:0]   rx_byte;
    logic         eot;
    logic         typed;
    swcc_result_t want;
  } stim_row_t;

  localparam swcc_result_t NO_WORD = '0;
  localparam int unsigned  N_ROWS  = 24;

  // typed rows: 0xBEEF carries check byte 0x92; a group cut short after its high byte zeroes the low byte
  localparam stim_row_t DIRECTED [0:N_ROWS-1] = '{
    '{8'hBE, 1'b0, 1'b0, NO_WORD},
    '{8'hEF, 1'b0, 1'b0, NO_WORD},
    '{8'h92, 1'b0, 1'b1, '{16'hBEEF, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{8'hBE, 1'b0, 1'b0, NO_WORD},
    '{8'hEF, 1'b0, 1'b0, NO_WORD},
    '{8'h93, 1'b1, 1'b1, '{16'hBEEF, 1'b0, 1'b1, 1'b0, 1'b1}},
    '{8'hFF, 1'b1, 1'b1, '{16'hFF00, 1'b0, 1'b1, 1'b1, 1'b1}},
    '{8'h00, 1'b0, 1'b0, NO_WORD},
    '{8'hFF, 1'b1, 1'b1, '{16'h00FF, 1'b0, 1'b1, 1'b1, 1'b1}},
    '{8'h00, 1'b1, 1'b1, '{16'h0000, 1'b0, 1'b1, 1'b1, 1'b1}},
    '{8'h00, 1'b0, 1'b0, NO_WORD},
    '{8'h00, 1'b0, 1'b0, NO_WORD},
    '{8'h00, 1'b0, 1'b0, NO_WORD},
    '{8'hFF, 1'b0, 1'b0, NO_WORD},
    '{8'hFF, 1'b0, 1'b0, NO_WORD},
    '{8'hFF, 1'b0, 1'b0, NO_WORD},
    '{8'hBE, 1'b0, 1'b0, NO_WORD},
    '{8'hEF, 1'b0, 1'b0, NO_WORD},
    '{8'h92, 1'b1, 1'b0, NO_WORD},
    '{8'h55, 1'b0, 1'b0, NO_WORD},
    '{8'hAA, 1'b1, 1'b1, '{16'h55AA, 1'b0, 1'b1, 1'b1, 1'b1}},
    '{8'hAA, 1'b0, 1'b0, NO_WORD},
    '{8'h55, 1'b0, 1'b0, NO_WORD},
    '{8'h00, 1'b1, 1'b0, NO_WORD}
  };

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  in_valid  = 1'b0;
  logic [IN_DATA_W-1:0]  in_byte   = '0;
  logic                  in_last   = 1'b0;
  logic                  out_ready = 1'b0;
  logic                  s_axis_tready_o;
  logic                  m_axis_tvalid_o;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  m_axis_tuser_o;
  logic                  m_axis_tlast_o;

  // model state
  logic [7:0] crc_acc    = CRC_INIT;
  logic [1:0] grp_pos    = GRP_DATA_HI;
  logic [7:0] hi_byte    = '0;
  logic [7:0] lo_byte    = '0;
  logic       xfer_err   = 1'b0;

  swcc_result_t expected_words[$];
  swcc_result_t want;

  int unsigned mismatch_count = 0;
  int unsigned bytes_sent     = 0;
  int unsigned transfer_count = 0;
  int unsigned words_checked  = 0;
  int unsigned bad_crc_count  = 0;
  int unsigned short_count    = 0;
  int unsigned idle_cycles    = 0;
  int          burst_left     = 4;
  bit          gaps_on        = 1'b1;
  bit          hold_req       = 1'b0;

  sensor_word_crc_checker_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (in_byte),         // [7:0] rx_byte
    .s_axis_tlast_i  (in_last),         // end_of_transfer
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),  // [15:0] word, [16] crc_ok, [17] error_seen
    .m_axis_tuser_o  (m_axis_tuser_o),  // short_group
    .m_axis_tlast_o  (m_axis_tlast_o)   // last
  );

  always #5 clk_i = ~clk_i;

  // bit-serial CRC-8, message bits MSB first
  function automatic logic [7:0] crc8_fold(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ b[i];
      c  = {c[6:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  // advance the model by one byte; returns 1 when a word comes out
  function automatic bit word_check_step(input logic [7:0] b, input logic eot,
                                         output swcc_result_t res);
    bit produced;
    bit restart;
    produced = 1'b0;
    restart  = eot;
    res      = '0;
    if (grp_pos == GRP_CHECK) begin
      res.word   = {hi_byte, lo_byte};
      res.crc_ok = (crc_acc == b);
      if (!res.crc_ok) begin
        xfer_err = 1'b1;
      end
      res.error_seen = xfer_err;
      res.last       = eot;
      produced       = 1'b1;
      restart        = 1'b1;
    end else begin
      crc_acc = crc8_fold(crc_acc, b);
      if (grp_pos == GRP_DATA_LO) begin
        lo_byte = b;
        grp_pos = GRP_CHECK;
      end else begin
        hi_byte = b;
        grp_pos = GRP_DATA_LO;
      end
      if (eot) begin
        res.word        = {hi_byte, lo_byte};
        res.error_seen  = 1'b1;
        res.short_group = 1'b1;
        res.last        = 1'b1;
        produced        = 1'b1;
      end
    end
    if (restart) begin
      crc_acc = CRC_INIT;
      grp_pos = GRP_DATA_HI;
      hi_byte = '0;
      lo_byte = '0;
    end
    if (eot) begin
      xfer_err = 1'b0;
    end
    return produced;
  endfunction

  task automatic report_mismatch(input string what, input logic [23:0] got,
                                 input logic [23:0] exp_val);
    $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $realtime, what, got, exp_val);
    mismatch_count++;
  endtask

  // offer one byte, hold until taken, then update the model
  task automatic send_byte(input logic [7:0] b, input logic eot, input bit typed,
                           input swcc_result_t typed_res);
    swcc_result_t res;
    bit           produced;
    in_byte  <= b;
    in_last  <= eot;
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    produced = word_check_step(b, eot, res);
    if (typed) begin
      res = typed_res;
    end
    if (produced || typed) begin
      expected_words.push_back(res);
      if (res.short_group) begin
        short_count++;
      end else if (!res.crc_ok) begin
        bad_crc_count++;
      end
    end
    bytes_sent++;
    if (gaps_on) begin
      burst_left--;
      if (burst_left <= 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        burst_left = $urandom_range(1, 16);
      end
    end
  endtask

  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_transfer();
    int         kind;
    int         n_groups;
    int unsigned r;
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] chk;
    bit         final_grp;
    r = $urandom_range(0, 99);
    kind     = (r < 8) ? KIND_NOISE : (r < 22) ? KIND_SHORT : KIND_FULL;
    n_groups = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 4);
    gaps_on  = ($urandom_range(0, 4) != 0);
    transfer_count++;
    if (kind == KIND_NOISE) begin
      n_groups = $urandom_range(1, 8);
      for (int i = 0; i < n_groups; i++) begin
        send_byte(pick_byte(), i == n_groups - 1, 1'b0, NO_WORD);
      end
    end else begin
      for (int g = 0; g < n_groups; g++) begin
        final_grp = (g == n_groups - 1);
        hi = pick_byte();
        lo = pick_byte();
        if (final_grp && kind == KIND_SHORT) begin
          if ($urandom_range(0, 1) == 1) begin
            send_byte(hi, 1'b1, 1'b0, NO_WORD);
          end else begin
            send_byte(hi, 1'b0, 1'b0, NO_WORD);
            send_byte(lo, 1'b1, 1'b0, NO_WORD);
          end
        end else begin
          send_byte(hi, 1'b0, 1'b0, NO_WORD);
          send_byte(lo, 1'b0, 1'b0, NO_WORD);
          chk = crc_acc;
          if ($urandom_range(0, 99) < 12) begin
            chk = chk ^ 8'($urandom_range(1, 255));
          end
          send_byte(chk, final_grp, 1'b0, NO_WORD);
        end
      end
    end
  endtask

  // park the sender and wait for every outstanding word
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
  endtask

  // receiver: a randomly chosen ready pattern, redrawn when its run ends
  initial begin
    int          mode;
    int unsigned period;
    int unsigned left;
    int unsigned cyc;
    mode   = 0;
    period = 2;
    left   = 0;
    cyc    = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        if (left == 0) begin
          mode   = $urandom_range(0, 2);
          period = $urandom_range(2, 5);
          left   = $urandom_range(20, 120);
        end
        left--;
        cyc++;
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ((cyc % period) != 0);
        endcase
      end
    end
  end

  // compare every accepted word with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && out_ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", m_axis_tdata_o, '0);
      end else begin
        want = expected_words.pop_front();
        words_checked++;
        if (m_axis_tdata_o[15:0] !== want.word) begin
          report_mismatch("word", 24'(m_axis_tdata_o[15:0]), 24'(want.word));
        end
        if (m_axis_tdata_o[16] !== want.crc_ok) begin
          report_mismatch("crc_ok", 24'(m_axis_tdata_o[16]), 24'(want.crc_ok));
        end
        if (m_axis_tdata_o[17] !== want.error_seen) begin
          report_mismatch("error_seen", 24'(m_axis_tdata_o[17]), 24'(want.error_seen));
        end
        if (m_axis_tdata_o[23:18] !== 6'd0) begin
          report_mismatch("tdata padding", 24'(m_axis_tdata_o[23:18]), 24'd0);
        end
        if (m_axis_tuser_o !== want.short_group) begin
          report_mismatch("short_group", 24'(m_axis_tuser_o), 24'(want.short_group));
        end
        if (m_axis_tlast_o !== want.last) begin
          report_mismatch("last", 24'(m_axis_tlast_o), 24'(want.last));
        end
      end
    end
  end

  // stop a hung run: count cycles with no word moving on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && s_axis_tready_o) || (m_axis_tvalid_o && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", idle_cycles);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned n_xfer;
    n_xfer = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_ROWS; i++) begin
      send_byte(DIRECTED[i].rx_byte, DIRECTED[i].eot, DIRECTED[i].typed, DIRECTED[i].want);
    end
    drain_results();

    while (bytes_sent < RANDOM_BYTES + N_ROWS) begin
      n_xfer++;
      // long receiver hold-off while the sender keeps offering
      if (n_xfer == 15) begin
        hold_req = 1'b1;
      end
      if (n_xfer == 40) begin
        drain_results();
      end
      send_transfer();
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d bytes in %0d random transfers plus a directed table", bytes_sent,
             transfer_count);
    $display("%0d words checked: %0d with a bad check byte, %0d short groups",
             words_checked, bad_crc_count, short_count);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
